// File: hdl/error_code_blink_cycler_macros.svh
// Assertion helpers for the blink cycler
`ifndef ERROR_CODE_BLINK_CYCLER_MACROS_SVH
`define ERROR_CODE_BLINK_CYCLER_MACROS_SVH

`ifndef SYNTHESIS
`define ECB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ECB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ECB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define ECB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/ecbc_pkg.sv
`timescale 1ns / 1ps

package ecbc_pkg;

    localparam int ADDR_W   = 3;
    localparam int CODE_W   = 4;
    localparam int CNT_W    = 8;
    localparam int PDATA_W  = 32;

    localparam logic [CNT_W-1:0] FRAMES_ON_RST  = 8'd10;
    localparam logic [CNT_W-1:0] FRAMES_OFF_RST = 8'd10;
    localparam logic [CNT_W-1:0] CNT_MAX        = 8'hFF;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } t_cmd;

    typedef enum logic {
        REG_FRAMES_ON  = 1'b0,
        REG_FRAMES_OFF = 1'b1
    } t_reg;

    // controller to datapath
    typedef struct packed {
        logic flag_wr;
        logic cnt_inc;
        logic go_dark;
        logic go_lit;
        logic scan_step;
        logic out_dark;
        logic out_code;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic any_active;
        logic lit_expire;
        logic dark_expire;
        logic scan_hit;
    } t_dp_sts;

endpackage

// File: hdl/ecbc_ctrl.sv
`timescale 1ns / 1ps

module ecbc_ctrl import ecbc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_command,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   accept;

    assign o_ready = (r_state == ST_IDLE) && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign accept  = i_valid && o_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_SET) begin
                        o_cmd.flag_wr = 1'b1;
                    end else begin
                        priority if (!i_sts.any_active) begin
                            o_cmd.out_dark = 1'b1;
                            n_valid        = 1'b1;
                        end else if (i_sts.lit_expire) begin
                            o_cmd.go_dark  = 1'b1;
                            o_cmd.out_dark = 1'b1;
                            n_valid        = 1'b1;
                        end else if (i_sts.dark_expire) begin
                            o_cmd.go_lit = 1'b1;
                            n_state      = ST_SCAN;
                        end else begin
                            o_cmd.cnt_inc = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN: begin
                // walk the flags one code a cycle until an active one turns up
                if (i_sts.scan_hit) begin
                    o_cmd.out_code = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

// File: hdl/ecbc_dp.sv
`timescale 1ns / 1ps

module ecbc_dp import ecbc_pkg::*; #(
    parameter int NUM_ERRORS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic [CODE_W-1:0]  i_error_index,
    input  logic               i_flag_value,
    input  logic               i_cfg_wr,
    input  logic               i_cfg_sel,
    input  logic [CNT_W-1:0]   i_cfg_data,
    output logic [PDATA_W-1:0] o_rdata,
    output logic               o_show_error,
    output logic [CODE_W-1:0]  o_shown_index
);

    localparam int IW = (NUM_ERRORS > 1) ? $clog2(NUM_ERRORS) : 1;

    logic [NUM_ERRORS-1:0] r_flags;
    logic [IW-1:0]         r_code;
    logic [IW-1:0]         n_code;
    logic                  r_lit;
    logic [CNT_W-1:0]      r_on_cnt;
    logic [CNT_W-1:0]      r_off_cnt;
    logic [CNT_W-1:0]      r_frames_on;
    logic [CNT_W-1:0]      r_frames_off;
    logic                  r_show;
    logic [CODE_W-1:0]     r_index;
    logic                  idx_ok;

    // round-robin successor of the current code
    assign n_code = (r_code == IW'(NUM_ERRORS - 1)) ? '0 : r_code + 1'b1;
    assign idx_ok = {1'b0, i_error_index} < (CODE_W + 1)'(NUM_ERRORS);

    assign o_sts.any_active  = |r_flags;
    assign o_sts.lit_expire  = r_lit && (r_on_cnt >= r_frames_on);
    assign o_sts.dark_expire = !r_lit && (r_off_cnt >= r_frames_off);
    assign o_sts.scan_hit    = r_flags[r_code];

    assign o_rdata = {{(PDATA_W - CNT_W){1'b0}},
                      (i_cfg_sel == REG_FRAMES_OFF) ? r_frames_off : r_frames_on};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags      <= '0;
            r_code       <= '0;
            r_lit        <= 1'b0;
            r_on_cnt     <= '0;
            r_off_cnt    <= '0;
            r_frames_on  <= FRAMES_ON_RST;
            r_frames_off <= FRAMES_OFF_RST;
        end else begin
            if (i_cfg_wr) begin
                if (i_cfg_sel == REG_FRAMES_OFF) begin
                    r_frames_off <= i_cfg_data;
                end else begin
                    r_frames_on <= i_cfg_data;
                end
            end
            if (i_cmd.flag_wr && idx_ok) begin
                r_flags[i_error_index[IW-1:0]] <= i_flag_value;
            end
            if (i_cmd.go_dark) begin
                r_on_cnt <= '0;
                r_lit    <= 1'b0;
            end
            if (i_cmd.go_lit) begin
                r_off_cnt <= '0;
                r_lit     <= 1'b1;
            end
            if (i_cmd.go_lit || i_cmd.scan_step) begin
                r_code <= n_code;
            end
            // hold at full scale rather than wrap
            if (i_cmd.cnt_inc) begin
                if (r_lit) begin
                    if (r_on_cnt != CNT_MAX) begin
                        r_on_cnt <= r_on_cnt + 1'b1;
                    end
                end else begin
                    if (r_off_cnt != CNT_MAX) begin
                        r_off_cnt <= r_off_cnt + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_dark) begin
            r_show  <= 1'b0;
            r_index <= '0;
        end else if (i_cmd.out_code) begin
            r_show  <= 1'b1;
            r_index <= CODE_W'(r_code);
        end
    end

    assign o_show_error  = r_show;
    assign o_shown_index = r_index;

endmodule

// File: hdl/error_code_blink_cycler.sv
// Set request: taken while the controller is idle, gives no result.
// Tick request: a result, if any, of a tick that does not light the display is valid the cycle
// after it is taken; a tick that lights it walks the flag table one code a cycle until a set flag.
// Throughput: one request a cycle while no result is held by i_ready low; none during a scan.
// Synchronous active-low reset clears all flags, counters and the phase, and loads
// both frame counts with 10.
`timescale 1ns / 1ps
`include "error_code_blink_cycler_macros.svh"

module error_code_blink_cycler import ecbc_pkg::*; #(
    parameter int NUM_ERRORS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_command,
    input  logic [CODE_W-1:0]  i_error_index,
    input  logic               i_flag_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_show_error,
    output logic [CODE_W-1:0]  o_shown_index,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    ecbc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .i_sts     (dp_sts),
        .o_cmd     (dp_cmd)
    );

    ecbc_dp #(
        .NUM_ERRORS (NUM_ERRORS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_error_index (i_error_index),
        .i_flag_value  (i_flag_value),
        .i_cfg_wr      (cfg_wr),
        .i_cfg_sel     (paddr[2]),
        .i_cfg_data    (pwdata[CNT_W-1:0]),
        .o_rdata       (prdata),
        .o_show_error  (o_show_error),
        .o_shown_index (o_shown_index)
    );

    `ECB_ASSERT_SAME(a_dark_index_zero, i_clk, i_rst_n, o_valid && !o_show_error, o_shown_index == '0, "dark result with nonzero index")
    `ECB_ASSERT_SAME(a_index_in_table, i_clk, i_rst_n, o_valid && o_show_error, {1'b0, o_shown_index} < (CODE_W + 1)'(NUM_ERRORS), "shown code outside table")
    `ECB_ASSERT_NEXT(a_set_no_result, i_clk, i_rst_n, i_valid && o_ready && (i_command == CMD_SET) && (!o_valid || i_ready), !o_valid, "set request produced a result")
    `ECB_ASSERT_SAME(a_scan_hit_active, i_clk, i_rst_n, dp_cmd.out_code, dp_sts.any_active && dp_sts.scan_hit, "code shown without an active flag")

endmodule
